### hw/rtl/pfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and letter/cell helpers for the playfair cipher.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int unsigned SIDE            = 5;
   localparam int unsigned CELLS           = SIDE * SIDE;
   localparam int unsigned ALPHA           = 26;
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   localparam logic [4:0] LETTER_I = 5'd8;
   localparam logic [4:0] LETTER_J = 5'd9;
   localparam logic [4:0] LETTER_Z = 5'(ALPHA - 1);

   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_type;
   typedef logic [2:0] coord_type;

   typedef enum logic [1:0] {
      CMD_KEY     = 2'd0,
      CMD_FINISH  = 2'd1,
      CMD_ENCRYPT = 2'd2,
      CMD_DECRYPT = 2'd3
   } cmd_type;

   // one queued item, classified by the front part
   typedef struct packed {
      cmd_type    cmd;
      logic       first;
      letter_type raw_a;
      letter_type raw_b;
      letter_type map_a;
      letter_type map_b;
   } item_type;

   typedef struct packed {
      logic     square_done;
      cell_type fill_count;
   } status_type;

   // pair letters: saturate to z, j reads as i
   function automatic letter_type map_letter(input letter_type l);
      if (l > LETTER_Z) begin
         return LETTER_Z;
      end
      if (l == LETTER_J) begin
         return LETTER_I;
      end
      return l;
   endfunction

   // cell index to row, by compare against row starts
   function automatic coord_type pos_row(input cell_type p);
      if (p >= 5'(4 * SIDE)) begin
         return 3'd4;
      end
      if (p >= 5'(3 * SIDE)) begin
         return 3'd3;
      end
      if (p >= 5'(2 * SIDE)) begin
         return 3'd2;
      end
      if (p >= 5'(SIDE)) begin
         return 3'd1;
      end
      return 3'd0;
   endfunction

   function automatic coord_type pos_col(input cell_type p);
      cell_type rem;
      rem = p - {pos_row(p), 2'b00} - 5'(pos_row(p));
      return rem[2:0];
   endfunction

   function automatic cell_type cell_of(input coord_type r, input coord_type c);
      return {r, 2'b00} + 5'(r) + 5'(c);
   endfunction

   // one step along a row or column, with wrap
   function automatic coord_type wrap_step(input coord_type v, input logic dec);
      if (dec) begin
         return (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
      end
      return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
   endfunction

endpackage

### hw/rtl/pfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_front
// Accepts items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module pfc_front #(
   parameter int unsigned QueueDepth = pfc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic              req_first_letter,
   input  logic [4:0]        req_letter_a,
   input  logic [4:0]        req_letter_b,
   output logic              q_valid,
   output pfc_pkg::item_type q_item,
   input  logic              q_pop
);
   import pfc_pkg::*;

   localparam int unsigned PtrW = $clog2(QueueDepth);
   localparam int unsigned CntW = $clog2(QueueDepth + 1);

   item_type          queue_ff [QueueDepth];
   logic [PtrW-1:0]   head_ff, head_in;
   logic [PtrW-1:0]   tail_ff, tail_in;
   logic [CntW-1:0]   count_ff, count_in;
   item_type          item_in;
   logic              push;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign req_ready = (count_ff != CntW'(QueueDepth));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[head_ff];

   always_comb begin
      item_in.cmd   = cmd_type'(req_cmd);
      item_in.first = req_first_letter;
      item_in.raw_a = req_letter_a;
      item_in.raw_b = req_letter_b;
      item_in.map_a = map_letter(req_letter_a);
      item_in.map_b = map_letter(req_letter_b);
   end

   always_comb begin
      head_in  = q_pop ? next_ptr(head_ff) : head_ff;
      tail_in  = push ? next_ptr(tail_ff) : tail_ff;
      count_in = count_ff;
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= item_in;
      end
   end

endmodule

### hw/rtl/pfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_back
// Builds the key square and runs pair lookups; owns the result register.
// ----------------------------------------------------------------------------
module pfc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  pfc_pkg::item_type   q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [4:0]          rsp_out_a,
   output logic [4:0]          rsp_out_b,
   output logic                rsp_not_ready,
   output pfc_pkg::status_type status
);
   import pfc_pkg::*;

   localparam logic [ALPHA-1:0] PLACED_INIT = ALPHA'(1) << LETTER_J;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_ADDR,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   cell_type         fill_ff, fill_in;
   logic             done_ff, done_in;
   logic [ALPHA-1:0] placed_ff, placed_in;
   letter_type       walk_ff, walk_in;
   logic             dec_ff, dec_in;
   logic             rsp_valid_ff, rsp_valid_in;
   letter_type       rsp_a_ff, rsp_a_in;
   letter_type       rsp_b_ff, rsp_b_in;
   logic             rsp_nr_ff, rsp_nr_in;

   cell_type         pos_mem [ALPHA];
   letter_type       sq_mem [CELLS];
   cell_type         pa_ff, pb_ff;
   letter_type       sa_ff, sb_ff;

   logic             out_free;
   logic             clear;
   logic             place_req;
   letter_type       place_ltr;
   logic [ALPHA-1:0] placed_base;
   cell_type         fill_base;
   logic             ltr_ok;
   logic             already;
   logic             do_place;
   coord_type        r1, c1, r2, c2;
   cell_type         o1, o2;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencing of one item at a time
   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      dec_in       = dec_ff;
      q_pop        = 1'b0;
      clear        = 1'b0;
      place_req    = 1'b0;
      place_ltr    = q_item.raw_a;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_nr_in    = rsp_nr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_item.cmd)
                  CMD_KEY: begin
                     q_pop     = 1'b1;
                     clear     = q_item.first;
                     place_req = 1'b1;
                     if (q_item.first) begin
                        done_in = 1'b0;
                     end
                  end
                  CMD_FINISH: begin
                     q_pop    = 1'b1;
                     walk_in  = '0;
                     state_in = ST_FILL;
                  end
                  default: begin
                     if (!done_ff) begin
                        // square unfinished: pass letters through flagged
                        if (out_free) begin
                           q_pop        = 1'b1;
                           rsp_valid_in = 1'b1;
                           rsp_a_in     = q_item.raw_a;
                           rsp_b_in     = q_item.raw_b;
                           rsp_nr_in    = 1'b1;
                        end
                     end else begin
                        q_pop    = 1'b1;
                        dec_in   = (q_item.cmd == CMD_DECRYPT);
                        state_in = ST_ADDR;
                     end
                  end
               endcase
            end
         end
         ST_FILL: begin
            place_req = 1'b1;
            place_ltr = walk_ff;
            if (walk_ff == LETTER_Z) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               walk_in = walk_ff + 5'd1;
            end
         end
         ST_ADDR: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_a_in     = sa_ff;
               rsp_b_in     = sb_ff;
               rsp_nr_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // letter placement into the next free cell
   always_comb begin
      placed_base = clear ? PLACED_INIT : placed_ff;
      fill_base   = clear ? '0 : fill_ff;
      ltr_ok      = (place_ltr <= LETTER_Z);
      already     = ltr_ok ? placed_base[place_ltr] : 1'b1;
      do_place    = place_req && !already && (fill_base < 5'(CELLS));
      placed_in   = placed_base;
      if (do_place) begin
         placed_in[place_ltr] = 1'b1;
      end
      fill_in = fill_base + 5'(do_place);
   end

   // pair rules on the looked-up positions
   always_comb begin
      r1 = pos_row(pa_ff);
      c1 = pos_col(pa_ff);
      r2 = pos_row(pb_ff);
      c2 = pos_col(pb_ff);
      if (c1 == c2) begin
         o1 = cell_of(wrap_step(r1, dec_ff), c1);
         o2 = cell_of(wrap_step(r2, dec_ff), c2);
      end else if (r1 == r2) begin
         o1 = cell_of(r1, wrap_step(c1, dec_ff));
         o2 = cell_of(r2, wrap_step(c2, dec_ff));
      end else begin
         o1 = cell_of(r1, c2);
         o2 = cell_of(r2, c1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         done_ff      <= 1'b0;
         placed_ff    <= PLACED_INIT;
         walk_ff      <= '0;
         dec_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         done_ff      <= done_in;
         placed_ff    <= placed_in;
         walk_ff      <= walk_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_a_ff  <= rsp_a_in;
      rsp_b_ff  <= rsp_b_in;
      rsp_nr_ff <= rsp_nr_in;
   end

   always_ff @(posedge clock) begin
      if (do_place) begin
         sq_mem[fill_base]  <= place_ltr;
         pos_mem[place_ltr] <= fill_base;
      end
      if (state_ff == ST_IDLE) begin
         pa_ff <= pos_mem[q_item.map_a];
         pb_ff <= pos_mem[q_item.map_b];
      end
      if (state_ff == ST_ADDR) begin
         sa_ff <= sq_mem[o1];
         sb_ff <= sq_mem[o2];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_a          = rsp_a_ff;
   assign rsp_out_b          = rsp_b_ff;
   assign rsp_not_ready      = rsp_nr_ff;
   assign status.square_done = done_ff;
   assign status.fill_count  = fill_ff;

endmodule

### hw/rtl/playfair_digraph_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// 5x5 playfair key square builder with pair encrypt and decrypt.
// ----------------------------------------------------------------------------
// Items enter a small queue and are executed one at a time by the back end.
// A key letter is popped and placed in the square; a finish takes the item
// and then walks every alphabet letter into the free cells; a pair before
// the square is finished passes through once the output register is free; an
// encrypt or decrypt pair goes through position lookup, square lookup and
// result load, set by the two registered memory reads.
// Results sit in an output register, so new items keep entering the queue,
// until it is full, while a result waits to be taken.
module playfair_digraph_cipher #(
   parameter int unsigned QueueDepth = pfc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic       req_first_letter,
   input  logic [4:0] req_letter_a,
   input  logic [4:0] req_letter_b,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_out_a,
   output logic [4:0] rsp_out_b,
   output logic       rsp_not_ready
);
   import pfc_pkg::*;

   logic       q_valid;
   logic       q_pop;
   item_type   q_item;
   status_type status;

   pfc_front #(
      .QueueDepth(QueueDepth)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_first_letter(req_first_letter),
      .req_letter_a    (req_letter_a),
      .req_letter_b    (req_letter_b),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   pfc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_a    (rsp_out_a),
      .rsp_out_b    (rsp_out_b),
      .rsp_not_ready(rsp_not_ready),
      .status       (status)
   );

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("outputs not quiet after reset");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      status.fill_count <= 5'(CELLS))
      else $error("fill count beyond square size");

   a_done_full : assert property (@(posedge clock) disable iff (reset)
      status.square_done |-> status.fill_count == 5'(CELLS))
      else $error("square finished with free cells");

   a_cipher_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_not_ready |-> rsp_out_a <= LETTER_Z && rsp_out_b <= LETTER_Z)
      else $error("cipher letter out of range");

endmodule

### verif/tb_playfair_digraph_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_playfair_digraph_cipher
// Self-checking bench for the playfair key square builder and pair cipher.
// A class keeps its own copy of the key square, updates it on every accepted
// item and queues the pair each encrypt or decrypt must return; results are
// checked in order. A short directed key build comes first, then random
// key sessions and noise under three sender/receiver idle mixes, including
// one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_playfair_digraph_cipher;
   import pfc_pkg::*;

   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned PHASE_ITEMS  = 545;

   typedef struct packed {
      letter_type a;
      letter_type b;
      logic       not_ready;
   } pair_result_type;

   class playfair_tracker;
      letter_type      grid[CELLS];
      cell_type        where[ALPHA];
      bit              placed[ALPHA];
      int unsigned     fill;
      bit              done;
      pair_result_type awaited[$];
      int unsigned     failures;
      int unsigned     pairs_checked;
      int unsigned     passthru_seen;
      int unsigned     squares_built;

      function new();
         foreach (grid[i]) grid[i] = '0;
         foreach (where[i]) where[i] = '0;
         clear_marks();
         failures      = 0;
         pairs_checked = 0;
         passthru_seen = 0;
         squares_built = 0;
      endfunction

      function void clear_marks();
         foreach (placed[i]) placed[i] = 1'b0;
         placed[LETTER_J] = 1'b1;
         fill = 0;
         done = 1'b0;
      endfunction

      function bit place(int unsigned l);
         if (l >= ALPHA || placed[l] || fill >= CELLS) begin
            return 1'b0;
         end
         grid[fill] = letter_type'(l);
         where[l]   = cell_type'(fill);
         placed[l]  = 1'b1;
         fill++;
         return 1'b1;
      endfunction

      // letters above z saturate, j reads as i
      function int unsigned square_letter(letter_type v);
         if (v > LETTER_Z) begin
            return LETTER_Z;
         end
         if (v == LETTER_J) begin
            return LETTER_I;
         end
         return v;
      endfunction

      // returns 1 when the item changed the square or produced a pair
      function bit note_item(cmd_type cmd, logic first, letter_type a, letter_type b);
         pair_result_type res;
         int unsigned     p1, p2, r1, c1, r2, c2, stp, o1, o2;
         bit              took;
         took = 1'b1;
         case (cmd)
            CMD_KEY: begin
               if (first) begin
                  clear_marks();
               end
               took = place(a) | first;
            end
            CMD_FINISH: begin
               for (int l = 0; l < ALPHA; l++) begin
                  void'(place(l));
               end
               done = 1'b1;
               squares_built++;
            end
            default: begin
               if (!done) begin
                  res.a         = a;
                  res.b         = b;
                  res.not_ready = 1'b1;
               end else begin
                  p1  = where[square_letter(a)];
                  p2  = where[square_letter(b)];
                  r1  = p1 / SIDE;
                  c1  = p1 % SIDE;
                  r2  = p2 / SIDE;
                  c2  = p2 % SIDE;
                  stp = (cmd == CMD_ENCRYPT) ? 1 : SIDE - 1;
                  if (c1 == c2) begin
                     o1 = ((r1 + stp) % SIDE) * SIDE + c1;
                     o2 = ((r2 + stp) % SIDE) * SIDE + c2;
                  end else if (r1 == r2) begin
                     o1 = r1 * SIDE + (c1 + stp) % SIDE;
                     o2 = r2 * SIDE + (c2 + stp) % SIDE;
                  end else begin
                     o1 = r1 * SIDE + c2;
                     o2 = r2 * SIDE + c1;
                  end
                  res.a         = grid[o1];
                  res.b         = grid[o2];
                  res.not_ready = 1'b0;
               end
               awaited.push_back(res);
            end
         endcase
         return took;
      endfunction

      function void check_pair(letter_type a, letter_type b, logic nr);
         pair_result_type want;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("unexpected pair out: a=%0d b=%0d not_ready=%0b", a, b, nr);
            end
            return;
         end
         want = awaited.pop_front();
         pairs_checked++;
         if (want.not_ready) begin
            passthru_seen++;
         end
         if (want.a !== a || want.b !== b || want.not_ready !== nr) begin
            failures++;
            if (failures <= 10) begin
               $display("pair mismatch: expected a=%0d b=%0d not_ready=%0b,",
                        want.a, want.b, want.not_ready,
                        " got a=%0d b=%0d not_ready=%0b", a, b, nr);
            end
         end
      endfunction
   endclass

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic [1:0] req_cmd          = CMD_KEY;
   logic       req_first_letter = 1'b0;
   logic [4:0] req_letter_a     = '0;
   logic [4:0] req_letter_b     = '0;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic [4:0] rsp_out_a;
   logic [4:0] rsp_out_b;
   logic       rsp_not_ready;

   playfair_tracker tracker;
   int unsigned     req_idle_pct = 0;
   int unsigned     rsp_idle_pct = 0;
   int unsigned     hold_cycles  = 0;
   int unsigned     items_taken  = 0;
   int unsigned     useful_items = 0;
   int unsigned     quiet_cycles = 0;

   playfair_digraph_cipher DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_first_letter (req_first_letter),
      .req_letter_a     (req_letter_a),
      .req_letter_b     (req_letter_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_a        (rsp_out_a),
      .rsp_out_b        (rsp_out_b),
      .rsp_not_ready    (rsp_not_ready)
   );

   always #4 clock = ~clock;

   // monitor: update the square on each accepted item, check each pair out
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            items_taken++;
            if (tracker.note_item(cmd_type'(req_cmd), req_first_letter,
                                  req_letter_a, req_letter_b)) begin
               useful_items++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            tracker.check_pair(rsp_out_a, rsp_out_b, rsp_not_ready);
         end
      end
   end

   // receiver: random ready, or a counted hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", quiet_cycles);
         $display("tb_playfair_digraph_cipher failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one item and hold it until the block takes it
   task automatic offer_item(cmd_type cmd, logic first, logic [4:0] a, logic [4:0] b);
      if (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_first_letter <= first;
      req_letter_a     <= a;
      req_letter_b     <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [4:0] draw_pair_letter();
      return ($urandom_range(9) == 0) ? 5'($urandom_range(26, 31)) : 5'($urandom_range(25));
   endfunction

   // mostly a full key build, finish and a run of pairs; sometimes raw noise
   task automatic run_session();
      int unsigned nkey;
      int unsigned npairs;
      logic [4:0]  a;
      logic [4:0]  b;
      if ($urandom_range(99) < 80) begin
         nkey = ($urandom_range(9) == 0) ? $urandom_range(26, 34) : $urandom_range(1, 12);
         for (int k = 0; k < nkey; k++) begin
            a = ($urandom_range(7) == 0) ? 5'($urandom_range(31))
                                         : 5'($urandom_range(25));
            offer_item(CMD_KEY, k == 0, a, 5'($urandom_range(31)));
         end
         offer_item(CMD_FINISH, 1'($urandom_range(1)), 5'($urandom_range(31)),
                    5'($urandom_range(31)));
         if ($urandom_range(9) == 0) begin
            offer_item(CMD_FINISH, 1'($urandom_range(1)), 5'($urandom_range(31)),
                       5'($urandom_range(31)));
         end
         npairs = $urandom_range(1, 24);
         for (int k = 0; k < npairs; k++) begin
            a = draw_pair_letter();
            b = ($urandom_range(19) == 0) ? a : draw_pair_letter();
            offer_item($urandom_range(1) ? CMD_ENCRYPT : CMD_DECRYPT,
                       1'($urandom_range(1)), a, b);
         end
      end else begin
         repeat ($urandom_range(1, 6)) begin
            offer_item(cmd_type'($urandom_range(3)), $urandom_range(4) == 0,
                       5'($urandom_range(31)), 5'($urandom_range(31)));
         end
      end
   endtask

   task automatic run_phase(int unsigned snd_pct, int unsigned rcv_pct, int unsigned target);
      int unsigned base;
      req_idle_pct = snd_pct;
      rsp_idle_pct = rcv_pct;
      base         = items_taken;
      while (items_taken - base < target) begin
         run_session();
      end
   endtask

   initial begin
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pairs before any square exists pass through flagged
      offer_item(CMD_ENCRYPT, 1'b0, 5'd31, 5'd0);
      offer_item(CMD_DECRYPT, 1'b1, 5'd26, 5'd9);
      // key "playfair example" with a duplicate, a j and an out-of-range letter
      offer_item(CMD_KEY, 1'b1, 5'd15, 5'd31);
      offer_item(CMD_KEY, 1'b0, 5'd11, 5'd0);
      offer_item(CMD_KEY, 1'b0, 5'd0, 5'd17);
      offer_item(CMD_KEY, 1'b0, 5'd24, 5'd3);
      offer_item(CMD_KEY, 1'b0, 5'd5, 5'd28);
      offer_item(CMD_KEY, 1'b0, 5'd0, 5'd9);
      offer_item(CMD_KEY, 1'b0, 5'd9, 5'd1);
      offer_item(CMD_KEY, 1'b0, 5'd8, 5'd22);
      offer_item(CMD_KEY, 1'b0, 5'd17, 5'd6);
      offer_item(CMD_KEY, 1'b0, 5'd4, 5'd12);
      offer_item(CMD_KEY, 1'b0, 5'd30, 5'd19);
      offer_item(CMD_KEY, 1'b0, 5'd23, 5'd4);
      offer_item(CMD_KEY, 1'b0, 5'd12, 5'd25);
      offer_item(CMD_FINISH, 1'b1, 5'd31, 5'd31);
      offer_item(CMD_FINISH, 1'b0, 5'd0, 5'd0);
      // rectangle, same row, same column, identical, j and saturated z
      offer_item(CMD_ENCRYPT, 1'b0, 5'd7, 5'd8);
      offer_item(CMD_ENCRYPT, 1'b1, 5'd15, 5'd11);
      offer_item(CMD_DECRYPT, 1'b0, 5'd15, 5'd8);
      offer_item(CMD_ENCRYPT, 1'b0, 5'd4, 5'd4);
      offer_item(CMD_DECRYPT, 1'b0, 5'd9, 5'd31);
      // late key letter is dropped; a clear with a bad letter empties the square
      offer_item(CMD_KEY, 1'b0, 5'd3, 5'd15);
      offer_item(CMD_KEY, 1'b1, 5'd31, 5'd31);
      offer_item(CMD_ENCRYPT, 1'b0, 5'd1, 5'd2);
      offer_item(CMD_FINISH, 1'b0, 5'd16, 5'd8);
      offer_item(CMD_DECRYPT, 1'b0, 5'd0, 5'd25);

      run_phase(19, 87, PHASE_ITEMS);
      run_phase(87, 19, PHASE_ITEMS);
      hold_cycles = LONG_HOLD;
      run_phase(0, 0, PHASE_ITEMS);

      req_valid <= 1'b0;
      while (tracker.awaited.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("accepted %0d items (%0d doing work), built %0d key squares",
               items_taken, useful_items, tracker.squares_built);
      $display("checked %0d pairs, %0d of them passed through before a finished square",
               tracker.pairs_checked, tracker.passthru_seen);
      if (tracker.failures == 0 && tracker.awaited.size() == 0) begin
         $display("tb_playfair_digraph_cipher passed");
      end else begin
         $display("%0d mismatches, %0d pairs never returned",
                  tracker.failures, tracker.awaited.size());
         $display("tb_playfair_digraph_cipher failed");
      end
      $finish;
   end

endmodule
